/* rtl/keyword_lexer_tokenizer_top_macros.svh */
// Assertion macros shared by the keyword lexer RTL.
// Included by the modules that carry concurrent assertions.
`ifndef KEYWORD_LEXER_TOKENIZER_TOP_MACROS_SVH
`define KEYWORD_LEXER_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KLT_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KLT_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/klt_pkg.sv */
// Package for the keyword lexer: token and scan types, queue entry type,
// keyword tables and character class functions. No dependencies.
package klt_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int QueueDepth = 4;
  localparam int OutWidth = 16;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_INT   = 2'd2,
    MODE_LABEL = 2'd3
  } scan_mode_t;

  typedef enum logic [3:0] {
    KIND_IDENT   = 4'd0,
    KIND_LABEL   = 4'd1,
    KIND_INT     = 4'd2,
    KIND_INPUT   = 4'd3,
    KIND_OUTPUT  = 4'd4,
    KIND_GOTO    = 4'd5,
    KIND_IF      = 4'd6,
    KIND_THEN    = 4'd7,
    KIND_EQUAL   = 4'd8,
    KIND_PLUS    = 4'd9,
    KIND_LESS    = 4'd10,
    KIND_INVALID = 4'd11,
    KIND_END     = 4'd12
  } token_code_t;

  typedef struct packed {
    token_code_t           kind;
    logic [OutWidth-1:0]   start;
    logic [OutWidth-1:0]   length;
  } token_t;

  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [7:0] CharEqual = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharLess  = 8'h3C;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharUnder = 8'h5F;
  localparam logic [7:0] CharEnd   = 8'hFF;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_name(logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CharUnder);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [2:0] kw_len(logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0: r = 3'd5;
      3'd1: r = 3'd6;
      3'd2: r = 3'd4;
      3'd3: r = 3'd2;
      3'd4: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] idx);
    logic [47:0] s;
    case (k)
      3'd0: s = {"input", 8'h00};
      3'd1: s = "output";
      3'd2: s = {"goto", 16'h0000};
      3'd3: s = {"if", 32'h0};
      3'd4: s = {"then", 16'h0000};
      default: s = 48'h0;
    endcase
    case (idx)
      3'd0: return s[47:40];
      3'd1: return s[39:32];
      3'd2: return s[31:24];
      3'd3: return s[23:16];
      3'd4: return s[15:8];
      3'd5: return s[7:0];
      default: return 8'h00;
    endcase
  endfunction

endpackage

/* rtl/klt_if.sv */
// Handshake interfaces for the keyword lexer: source bytes in, tokens out.
// Depends on nothing.
interface klt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, output data_byte, output end_marker, input ready);
  modport sink (input valid, input data_byte, input end_marker, output ready);
endinterface

interface klt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_code;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        run_last;

  modport source (output valid, output token_code, output token_start,
                  output token_length, output run_last, input ready);
  modport sink (input valid, input token_code, input token_start,
                input token_length, input run_last, output ready);
endinterface

/* rtl/klt_front.sv */
// Front part of the keyword lexer: accepts bytes, tracks the pending token
// and pushes the tokens each item causes into the queue. Uses klt_pkg.
module klt_front
  import klt_pkg::*;
#(
  parameter int POSITION_BITS = PositionBitsDefault
) (
  input  logic          clk,
  input  logic          rst,
  klt_in_if.sink        in_items,
  input  queue_status_t q_status,
  output logic          q_push,
  output queue_entry_t  q_entry
);

  localparam int LenBits = (POSITION_BITS < 16) ? POSITION_BITS : 16;

  scan_mode_t               mode, mode_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] pending_start, pending_start_next;
  logic [LenBits-1:0]       pending_length, pending_length_next;
  logic [4:0]               match_mask, match_mask_next;

  logic [7:0]               c;
  logic                     accept;
  logic                     is_end;
  logic                     cont;
  logic                     do_flush;
  logic                     has_byte_tok;
  logic [POSITION_BITS-1:0] pos_inc;
  token_code_t              flush_kind;
  token_t                   flush_tok;
  token_t                   byte_tok;

  function automatic logic [4:0] match_next(logic [4:0] m, logic [LenBits-1:0] len,
                                            logic [7:0] ch);
    logic [4:0] r;
    r = m;
    for (int k = 0; k < 5; k++) begin
      if ((len >= LenBits'(kw_len(3'(k)))) || (kw_char(3'(k), len[2:0]) != ch)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  assign c            = in_items.data_byte;
  assign in_items.ready = !q_status.full;
  assign accept       = in_items.valid && in_items.ready;
  assign is_end       = in_items.end_marker || (c == CharEnd);
  assign pos_inc      = byte_position + POSITION_BITS'(1);
  assign cont         = !is_end && (((mode == MODE_INT) && is_digit(c)) ||
                        (((mode == MODE_IDENT) || (mode == MODE_LABEL)) && is_name(c)));
  assign do_flush     = !cont && (mode != MODE_IDLE);

  always_comb begin
    flush_kind = KIND_IDENT;
    case (mode)
      MODE_INT: flush_kind = KIND_INT;
      MODE_LABEL: flush_kind = KIND_LABEL;
      default: begin
        for (int k = 4; k >= 0; k--) begin
          if (match_mask[k] && (pending_length == LenBits'(kw_len(3'(k))))) begin
            flush_kind = token_code_t'(4'(int'(KIND_INPUT) + k));
          end
        end
      end
    endcase
  end

  // Next state of the scanner.
  always_comb begin
    mode_next           = mode;
    byte_position_next  = byte_position;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    match_mask_next     = match_mask;
    if (is_end) begin
      mode_next           = MODE_IDLE;
      byte_position_next  = '0;
      pending_start_next  = '0;
      pending_length_next = '0;
      match_mask_next     = '1;
    end else if (cont) begin
      byte_position_next = pos_inc;
      if (mode == MODE_IDENT) begin
        match_mask_next = match_next(match_mask, pending_length, c);
      end
      if (!(&pending_length)) begin
        pending_length_next = pending_length + LenBits'(1);
      end
    end else begin
      byte_position_next  = pos_inc;
      mode_next           = MODE_IDLE;
      pending_start_next  = '0;
      pending_length_next = '0;
      match_mask_next     = '1;
      if (is_space(c)) begin
        mode_next = MODE_IDLE;
      end else if (c == CharColon) begin
        mode_next          = MODE_LABEL;
        pending_start_next = pos_inc;
      end else if (is_digit(c)) begin
        mode_next           = MODE_INT;
        pending_start_next  = byte_position;
        pending_length_next = LenBits'(1);
      end else if (is_name(c)) begin
        mode_next           = MODE_IDENT;
        pending_start_next  = byte_position;
        pending_length_next = LenBits'(1);
        match_mask_next     = match_next('1, '0, c);
      end
    end
  end

  // Tokens caused by the current item.
  always_comb begin
    flush_tok.kind   = flush_kind;
    flush_tok.start  = OutWidth'(pending_start);
    flush_tok.length = OutWidth'(pending_length);
    byte_tok.kind    = KIND_INVALID;
    byte_tok.start   = OutWidth'(byte_position);
    byte_tok.length  = OutWidth'(1);
    has_byte_tok     = 1'b0;
    if (is_end) begin
      byte_tok.kind   = KIND_END;
      byte_tok.length = '0;
      has_byte_tok    = 1'b1;
    end else if (!cont) begin
      if (c == CharEqual) begin
        byte_tok.kind = KIND_EQUAL;
        has_byte_tok  = 1'b1;
      end else if (c == CharPlus) begin
        byte_tok.kind = KIND_PLUS;
        has_byte_tok  = 1'b1;
      end else if (c == CharLess) begin
        byte_tok.kind = KIND_LESS;
        has_byte_tok  = 1'b1;
      end else if (!is_space(c) && (c != CharColon) && !is_name(c)) begin
        has_byte_tok = 1'b1;
      end
    end
    q_entry.first  = do_flush ? flush_tok : byte_tok;
    q_entry.second = byte_tok;
    q_entry.two    = do_flush && has_byte_tok;
    q_push         = accept && (do_flush || has_byte_tok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      byte_position  <= '0;
      pending_start  <= '0;
      pending_length <= '0;
      match_mask     <= '1;
    end else if (accept) begin
      mode           <= mode_next;
      byte_position  <= byte_position_next;
      pending_start  <= pending_start_next;
      pending_length <= pending_length_next;
      match_mask     <= match_mask_next;
    end
  end

endmodule

/* rtl/klt_queue.sv */
// Short register queue of token entries between front and back parts.
// Uses klt_pkg and the assertion macros.
`include "keyword_lexer_tokenizer_top_macros.svh"
module klt_queue
  import klt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  queue_entry_t  push_entry,
  input  logic          pop,
  output queue_entry_t  head,
  output queue_status_t status
);

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CountBits = $clog2(QueueDepth + 1);

  queue_entry_t         entries [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [CountBits-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign status.full  = (count == CountBits'(QueueDepth));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr + PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr + PtrBits'(1);
      end
      count <= count + CountBits'(do_push) - CountBits'(do_pop);
    end
  end

  `KLT_ASSERT_NOW(a_no_push_full, clk, rst, push, !status.full, "Push into a full queue.")
  `KLT_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !status.empty, "Pop from an empty queue.")

endmodule

/* rtl/klt_back.sv */
// Back part of the keyword lexer: splits queue entries into single tokens
// and holds them in the output register. Uses klt_pkg and the macros.
`include "keyword_lexer_tokenizer_top_macros.svh"
module klt_back
  import klt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  queue_entry_t  q_head,
  input  queue_status_t q_status,
  output logic          q_pop,
  klt_out_if.source     tokens
);

  logic   out_valid;
  token_t out_tok;
  logic   out_last;
  logic   phase, phase_next;
  logic   load;
  logic   sel_last;
  token_t sel_tok;

  assign load     = !q_status.empty && (!out_valid || tokens.ready);
  assign sel_tok  = phase ? q_head.second : q_head.first;
  assign sel_last = phase || !q_head.two;
  assign q_pop    = load && sel_last;

  always_comb begin
    phase_next = phase;
    if (load) begin
      phase_next = !sel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= sel_tok;
      out_last <= sel_last;
    end
  end

  assign tokens.valid        = out_valid;
  assign tokens.token_code   = out_tok.kind;
  assign tokens.token_start  = out_tok.start;
  assign tokens.token_length = out_tok.length;
  assign tokens.run_last     = out_last;

  `KLT_ASSERT_NOW(a_phase_entry, clk, rst, phase, !q_status.empty && q_head.two,
    "Second token pending without a two-token entry.")
  `KLT_ASSERT_NEXT(a_split_phase, clk, rst, load && !sel_last, phase && !out_last,
    "First of two tokens did not leave the second pending.")
  `KLT_ASSERT_NOW(a_pop_last, clk, rst, q_pop, sel_last,
    "Entry popped before its last token.")

endmodule

/* rtl/keyword_lexer_tokenizer_top.sv */
// Top level of the keyword lexer: front part, token queue and back part.
// Uses klt_pkg, klt_if, klt_front, klt_queue and klt_back.
//
//   Channel    Dir  Payload                                            Accepted when
//   in_items   in   data_byte[7:0], end_marker                         valid && ready
//   tokens     out  token_code[3:0], token_start[15:0],                valid && ready
//                   token_length[15:0], run_last
//
// The front part takes one byte per cycle while the four-entry queue has room.
// An item that yields two tokens leaves through the single output register one
// token at a time, and its queue entry is popped only with its second token.
// Each token is registered in the output register from the head of the queue.
// Reset is synchronous; after it the scanner is between tokens at offset 0.
// A stalled output fills the queue and then holds ready low on the input.
module keyword_lexer_tokenizer_top
  import klt_pkg::*;
#(
  parameter int POSITION_BITS = PositionBitsDefault
) (
  input logic        clk,
  input logic        rst,
  klt_in_if.sink     in_items,
  klt_out_if.source  tokens
);

  queue_status_t q_status;
  queue_entry_t  push_entry;
  queue_entry_t  q_head;
  logic          q_push;
  logic          q_pop;

  klt_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_items (in_items),
    .q_status (q_status),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  klt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  klt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_status (q_status),
    .q_pop    (q_pop),
    .tokens   (tokens)
  );

endmodule
